/* hdl/hbrc_pkg.sv */
// ----------------------------------------------------------------------------
// hbrc_pkg
// Types and constants shared by the H-bridge reversal controller modules.
// ----------------------------------------------------------------------------
package hbrc_pkg;

    localparam int unsigned ADC_W      = 12;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned HOLD_W     = 10;

    localparam logic [ADC_W-1:0]  ADC_FULL   = 12'd4095;
    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 8'd255;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd30;

    // floor(y / 100) == (y * DIV100_RECIP) >> DIV100_SHIFT for y <= 25500
    localparam int unsigned       DIV100_SHIFT = 19;
    localparam logic [12:0]       DIV100_RECIP = 13'd5243;

    localparam logic GO_RIGHT = 1'b0;
    localparam logic GO_LEFT  = 1'b1;

    typedef struct packed {
        logic             btn_right_level;
        logic             btn_left_level;
        logic [ADC_W-1:0] adc_sample;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] hs_left_duty;
        logic [DUTY_W-1:0] hs_right_duty;
        logic              ls_left_on;
        logic              ls_right_on;
        logic              led_green;
        logic              led_red;
        logic [PCT_W-1:0]  power_percent;
        logic              reversing;
    } t_out;

endpackage

/* hdl/hbrc_scale.sv */
// ----------------------------------------------------------------------------
// hbrc_scale
// Scales a 12-bit sample to percent (0..100) and duty (0..255).
// ----------------------------------------------------------------------------
module hbrc_scale (
    input  logic [hbrc_pkg::ADC_W-1:0]  i_adc_sample,
    output logic [hbrc_pkg::PCT_W-1:0]  o_percent,
    output logic [hbrc_pkg::DUTY_W-1:0] o_duty
);
    import hbrc_pkg::*;

    logic [18:0] prod;
    logic [6:0]  q0;
    logic [12:0] rem;
    logic [14:0] duty_num;
    logic [27:0] duty_prod;

    // sample*100/4095: x>>12 undershoots by at most one step
    assign prod = {7'd0, i_adc_sample} * {12'd0, PCT_FULL};
    assign q0   = prod[18:12];
    assign rem  = {1'b0, prod[11:0]} + {6'd0, q0};
    assign o_percent = q0 + {6'd0, (rem >= {1'b0, ADC_FULL})};

    assign duty_num  = {8'd0, o_percent} * {7'd0, DUTY_FULL};
    assign duty_prod = {13'd0, duty_num} * {15'd0, DIV100_RECIP};
    assign o_duty    = duty_prod[DIV100_SHIFT +: DUTY_W];

endmodule

/* hdl/hbrc_ctrl.sv */
// ----------------------------------------------------------------------------
// hbrc_ctrl
// Button edge detection, direction state, reversal hold and bridge drive.
// ----------------------------------------------------------------------------
module hbrc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  hbrc_pkg::t_in               i_item,
    input  logic [hbrc_pkg::HOLD_W-1:0] i_hold_ticks,
    input  logic [hbrc_pkg::PCT_W-1:0]  i_percent,
    input  logic [hbrc_pkg::DUTY_W-1:0] i_duty,
    output hbrc_pkg::t_out              o_result
);
    import hbrc_pkg::*;

    logic              r_prev_right, n_prev_right;
    logic              r_prev_left,  n_prev_left;
    logic              r_active,     n_active;
    logic              r_wanted,     n_wanted;
    logic              r_pending,    n_pending;
    logic [HOLD_W-1:0] r_hold,       n_hold;
    logic              rev;
    logic              drive;

    always_comb begin
        n_prev_right = i_item.btn_right_level;
        n_prev_left  = i_item.btn_left_level;
        n_active     = r_active;
        n_wanted     = r_wanted;
        n_pending    = r_pending;
        n_hold       = r_hold;
        rev          = 1'b0;

        if (r_prev_right && !i_item.btn_right_level) begin
            n_wanted = GO_RIGHT;
            if (GO_RIGHT != r_active) begin
                if (!n_pending) begin
                    n_hold = i_hold_ticks;
                end
                n_pending = 1'b1;
            end
        end
        if (r_prev_left && !i_item.btn_left_level) begin
            n_wanted = GO_LEFT;
            if (GO_LEFT != r_active) begin
                if (!n_pending) begin
                    n_hold = i_hold_ticks;
                end
                n_pending = 1'b1;
            end
        end

        if (n_pending) begin
            if (n_hold == '0) begin
                n_active  = n_wanted;
                n_pending = 1'b0;
            end else begin
                n_hold = n_hold - 1'b1;
                rev    = 1'b1;
            end
        end

        drive = !rev && (i_duty != '0);

        o_result.hs_left_duty  = (drive && n_active == GO_RIGHT) ? i_duty : '0;
        o_result.hs_right_duty = (drive && n_active == GO_LEFT)  ? i_duty : '0;
        o_result.ls_left_on    = drive && (n_active == GO_LEFT);
        o_result.ls_right_on   = drive && (n_active == GO_RIGHT);
        o_result.led_green     = (n_active == GO_RIGHT);
        o_result.led_red       = (n_active == GO_LEFT);
        o_result.power_percent = i_percent;
        o_result.reversing     = rev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_right <= 1'b1;
            r_prev_left  <= 1'b1;
            r_active     <= GO_RIGHT;
            r_wanted     <= GO_RIGHT;
            r_pending    <= 1'b0;
            r_hold       <= '0;
        end else if (i_advance) begin
            r_prev_right <= n_prev_right;
            r_prev_left  <= n_prev_left;
            r_active     <= n_active;
            r_wanted     <= n_wanted;
            r_pending    <= n_pending;
            r_hold       <= n_hold;
        end
    end

endmodule

/* hdl/h_bridge_reversal_controller.sv */
// ----------------------------------------------------------------------------
// h_bridge_reversal_controller
// One transaction per control tick: two active-low buttons and a pot sample
// in, H-bridge drive, LEDs, power percent and reversing flag out. Each
// transaction is registered at the input, evaluated in one pass of logic and
// registered at the output, so a transaction is taken every clock while the
// output is not stalled; a result goes from the input register through the
// logic into the output register once the output is free. A stalled
// output holds the pipeline. A direction change holds the bridge off for
// r_hold_ticks transactions before it commits.
// ----------------------------------------------------------------------------
module h_bridge_reversal_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hbrc_pkg::HOLD_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  hbrc_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output hbrc_pkg::t_out              o_out_data
);
    import hbrc_pkg::*;

    logic [HOLD_W-1:0] r_hold_ticks;
    logic              r_in_valid;
    t_in               r_in_data;
    logic              r_out_valid;
    t_out              r_out_data;
    logic              advance;
    logic [PCT_W-1:0]  percent;
    logic [DUTY_W-1:0] duty;
    t_out              result;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    hbrc_scale u_scale (
        .i_adc_sample (r_in_data.adc_sample),
        .o_percent    (percent),
        .o_duty       (duty)
    );

    hbrc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_in_data),
        .i_hold_ticks (r_hold_ticks),
        .i_percent    (percent),
        .i_duty       (duty),
        .o_result     (result)
    );

endmodule
